@@ hw/rtl/bsr_pkg.sv @@
// bsr_pkg: shared types and constants for the byte stream reassembler
// used by bsr_cell, byte_stream_reassembler_unit and bsr_checker; no dependencies
package bsr_pkg;

  localparam int unsigned RESULT_LIMIT = 64;
  localparam int unsigned RUN_W        = 7;
  localparam int unsigned WSIZE_W      = 7;
  localparam int unsigned POS_W        = 32;
  localparam int unsigned PEND_W       = 7;
  localparam logic [WSIZE_W-1:0] WSIZE_RESET = 7'd64;

  typedef struct packed {
    logic       valid;
    logic       end_mark;
    logic [7:0] data;
  } cell_t;

  typedef struct packed {
    logic       shift;
    logic       clear;
    logic       wr_byte;
    logic       set_end;
    logic [7:0] data;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/bsr_cell.sv @@
// bsr_cell: one window slot of the reassembly chain, holds byte, valid and end mark
// shifts toward the head on drain; depends on bsr_pkg
module bsr_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bsr_pkg::cell_ctrl_t ctrl_i,
  input  bsr_pkg::cell_t     next_i,
  output bsr_pkg::cell_t     cell_o
);
  import bsr_pkg::*;

  logic       valid_q, valid_d;
  logic       end_q, end_d;
  logic [7:0] data_q;

  always_comb begin
    valid_d = valid_q;
    end_d   = end_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
      end_d   = 1'b0;
    end else if (ctrl_i.shift) begin
      valid_d = next_i.valid;
      end_d   = next_i.end_mark;
    end else begin
      if (ctrl_i.wr_byte) valid_d = 1'b1;
      if (ctrl_i.set_end) end_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      end_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      end_q   <= end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      data_q <= next_i.data;
    end else if (ctrl_i.wr_byte && !valid_q) begin
      data_q <= ctrl_i.data;
    end
  end

  assign cell_o = '{valid: valid_q, end_mark: end_q, data: data_q};

endmodule

@@ hw/rtl/byte_stream_reassembler_unit.sv @@
// byte_stream_reassembler_unit: in-order byte delivery from out-of-order requests
// a request is taken only in the idle state and yields 1 to 64 results; no new request
// is taken until its last result has been registered. results leave one per cycle,
// while the result output is not stalled, through the output register, set by the drain
// shifting the cell chain one slot per result. async active-low reset empties the window,
// sets window size to 64. depends on bsr_pkg and bsr_cell
module byte_stream_reassembler_unit #(
  parameter int unsigned WINDOW_DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bsr_pkg::WSIZE_W-1:0] cfg_wdata_i,
  input  logic                       req_valid_i,
  output logic                       req_stall_o,
  input  logic [bsr_pkg::POS_W-1:0]  position_i,
  input  logic [7:0]                 byte_value_i,
  input  logic                       has_byte_i,
  input  logic                       ends_stream_i,
  output logic                       res_valid_o,
  input  logic                       res_stall_i,
  output logic                       out_valid_o,
  output logic [7:0]                 out_byte_o,
  output logic                       stream_ended_o,
  output logic [bsr_pkg::PEND_W-1:0] pending_count_o,
  output logic [bsr_pkg::POS_W-1:0]  next_expected_o,
  output logic                       last_of_run_o
);
  import bsr_pkg::*;

  localparam int unsigned IDX_W  = $clog2(WINDOW_DEPTH);
  localparam int unsigned HELD_W = $clog2(WINDOW_DEPTH + 1);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_DRAIN = 1'b1;

  logic                state_q, state_d;
  logic [WSIZE_W-1:0]  wsize_q;
  logic [POS_W-1:0]    exp_q, exp_d;
  logic [HELD_W-1:0]   held_q, held_d;
  logic                ended_q, ended_d;
  logic [RUN_W-1:0]    run_q, run_d;

  logic                res_valid_q;
  logic                outv_q;
  logic [7:0]          obyte_q;
  logic                oended_q;
  logic [PEND_W-1:0]   opend_q;
  logic [POS_W-1:0]    oexp_q;
  logic                olast_q;

  cell_t               cells [WINDOW_DEPTH];
  cell_ctrl_t          ctrl  [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] valid_vec;

  logic [POS_W-1:0]    offset, moff, eff;
  logic [IDX_W-1:0]    widx, midx;
  logic                accept, do_wr, byte_hit, mark_hit, mark_now, new_byte;
  logic                out_free, can_drain, drain_fire, status_fire, fin, last;

  always_comb begin
    offset   = position_i - exp_q;
    moff     = offset - 32'd1;
    eff      = (32'(wsize_q) < 32'(WINDOW_DEPTH)) ? 32'(wsize_q) : 32'(WINDOW_DEPTH);
    widx     = offset[IDX_W-1:0];
    midx     = moff[IDX_W-1:0];
    accept   = (state_q == S_IDLE) && req_valid_i;
    do_wr    = accept && !ended_q;
    byte_hit = has_byte_i && (offset < eff);
    mark_now = !has_byte_i && ends_stream_i && (offset == '0);
    mark_hit = !has_byte_i && ends_stream_i && (offset != '0) && (moff < eff);
    new_byte = do_wr && byte_hit && !valid_vec[widx];

    out_free    = !res_valid_q || !res_stall_i;
    can_drain   = !ended_q && cells[0].valid;
    drain_fire  = (state_q == S_DRAIN) && out_free && can_drain;
    status_fire = (state_q == S_DRAIN) && out_free && !can_drain;
    fin         = cells[0].end_mark;
    last        = fin || (run_q == RUN_W'(RESULT_LIMIT - 1)) || !cells[1].valid;
  end

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_chain
    always_comb begin
      ctrl[i].shift   = drain_fire;
      ctrl[i].clear   = (do_wr && mark_now) || (drain_fire && fin);
      ctrl[i].wr_byte = do_wr && byte_hit && (widx == IDX_W'(i));
      ctrl[i].set_end = do_wr && ((byte_hit && ends_stream_i && (widx == IDX_W'(i))) ||
                                  (mark_hit && (midx == IDX_W'(i))));
      ctrl[i].data    = byte_value_i;
    end
    assign valid_vec[i] = cells[i].valid;
    if (i == WINDOW_DEPTH - 1) begin : g_tail
      bsr_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (ctrl[i]),
        .next_i ('0),
        .cell_o (cells[i])
      );
    end else begin : g_body
      bsr_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (ctrl[i]),
        .next_i (cells[i+1]),
        .cell_o (cells[i])
      );
    end
  end

  always_comb begin
    state_d = state_q;
    exp_d   = exp_q;
    held_d  = held_q;
    ended_d = ended_q;
    run_d   = run_q;
    if (accept) begin
      state_d = S_DRAIN;
      run_d   = '0;
      if (do_wr && mark_now) begin
        ended_d = 1'b1;
        held_d  = '0;
      end else if (new_byte) begin
        held_d = held_q + HELD_W'(1);
      end
    end
    if (drain_fire) begin
      exp_d  = exp_q + 32'd1;
      run_d  = run_q + RUN_W'(1);
      held_d = fin ? '0 : held_q - HELD_W'(1);
      if (fin) ended_d = 1'b1;
      if (last) state_d = S_IDLE;
    end
    if (status_fire) state_d = S_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wsize_q     <= WSIZE_RESET;
      exp_q       <= '0;
      held_q      <= '0;
      ended_q     <= 1'b0;
      run_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      exp_q   <= exp_d;
      held_q  <= held_d;
      ended_q <= ended_d;
      run_q   <= run_d;
      if (cfg_we_i) wsize_q <= cfg_wdata_i;
      if (drain_fire || status_fire) begin
        res_valid_q <= 1'b1;
      end else if (!res_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (drain_fire) begin
      outv_q   <= 1'b1;
      obyte_q  <= cells[0].data;
      oended_q <= ended_d;
      opend_q  <= PEND_W'(held_d);
      oexp_q   <= exp_d;
      olast_q  <= last;
    end else if (status_fire) begin
      outv_q   <= 1'b0;
      obyte_q  <= 8'd0;
      oended_q <= ended_q;
      opend_q  <= PEND_W'(held_q);
      oexp_q   <= exp_q;
      olast_q  <= 1'b1;
    end
  end

  assign req_stall_o     = (state_q != S_IDLE);
  assign res_valid_o     = res_valid_q;
  assign out_valid_o     = outv_q;
  assign out_byte_o      = obyte_q;
  assign stream_ended_o  = oended_q;
  assign pending_count_o = opend_q;
  assign next_expected_o = oexp_q;
  assign last_of_run_o   = olast_q;

endmodule

@@ hw/rtl/bsr_checker.sv @@
// bsr_checker: port-level assertions for byte_stream_reassembler_unit
// bound to the top level below; depends on bsr_pkg
module bsr_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_stall_o,
  input logic                       res_valid_o,
  input logic                       res_stall_i,
  input logic                       out_valid_o,
  input logic [7:0]                 out_byte_o,
  input logic [bsr_pkg::POS_W-1:0]  next_expected_o,
  input logic                       last_of_run_o
);
  import bsr_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> res_valid_o && $stable(out_byte_o) &&
                                   $stable(next_expected_o) && $stable(last_of_run_o))
    else $error("result changed while stalled");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && !req_stall_o |=> req_stall_o)
    else $error("new request taken before results of previous one");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !out_valid_o |-> last_of_run_o)
    else $error("status result not last of run");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !out_valid_o |-> out_byte_o == 8'd0)
    else $error("status result carries nonzero byte");

endmodule

bind byte_stream_reassembler_unit bsr_checker u_bsr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_valid_i),
  .req_stall_o     (req_stall_o),
  .res_valid_o     (res_valid_o),
  .res_stall_i     (res_stall_i),
  .out_valid_o     (out_valid_o),
  .out_byte_o      (out_byte_o),
  .next_expected_o (next_expected_o),
  .last_of_run_o   (last_of_run_o)
);
